[src/i2cwrm_pkg.sv]
`default_nettype none

package i2cwrm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_START_A   = 4'd1,
        ST_START_B   = 4'd2,
        ST_START_C   = 4'd3,
        ST_WBIT_LOW  = 4'd4,
        ST_WBIT_HIGH = 4'd5,
        ST_WBIT_TAIL = 4'd6,
        ST_SACK_HIGH = 4'd7,
        ST_SACK_LOW  = 4'd8,
        ST_RBIT_LOW  = 4'd9,
        ST_RBIT_HIGH = 4'd10,
        ST_MACK_LOW  = 4'd11,
        ST_MACK_HIGH = 4'd12,
        ST_STOP_A    = 4'd13,
        ST_STOP_B    = 4'd14
    } t_step;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

    localparam logic [2:0] STAGE_ADDR    = 3'd0;
    localparam logic [2:0] STAGE_REG     = 3'd1;
    localparam logic [2:0] STAGE_DATA_HI = 3'd2;
    localparam logic [2:0] STAGE_DATA_LO = 3'd3;
    localparam logic [2:0] STAGE_ADDR_RD = 3'd4;
    localparam logic [2:0] STAGE_RD_HI   = 3'd5;
    localparam logic [2:0] STAGE_RD_LO   = 3'd6;
    localparam logic [2:0] STAGE_END     = 3'd7;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_word;
        logic        nack_seen;
    } t_result;

    function automatic logic [7:0] load_byte(input logic [2:0] stage,
                                             input logic [7:0] addr,
                                             input logic [7:0] reg_b,
                                             input logic [15:0] data);
        logic [7:0] b;
        unique case (stage)
            STAGE_ADDR:    b = addr;
            STAGE_REG:     b = reg_b;
            STAGE_DATA_HI: b = data[15:8];
            STAGE_DATA_LO: b = data[7:0];
            default:       b = addr + 8'd1;
        endcase
        return b;
    endfunction

    function automatic logic step_is_long(input t_step s);
        logic l;
        unique case (s)
            ST_START_A, ST_START_B, ST_START_C,
            ST_SACK_HIGH, ST_SACK_LOW,
            ST_STOP_A, ST_STOP_B: l = 1'b1;
            default:              l = 1'b0;
        endcase
        return l;
    endfunction

    function automatic logic step_scl(input t_step s);
        logic c;
        unique case (s)
            ST_START_C, ST_WBIT_LOW, ST_WBIT_TAIL, ST_SACK_LOW,
            ST_RBIT_LOW, ST_MACK_LOW: c = 1'b0;
            default:                  c = 1'b1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[src/i2cwrm_seq.sv]
`default_nettype none

module i2cwrm_seq
    import i2cwrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_slave_addr,
    input  wire logic [7:0]  i_reg_ptr,
    input  wire logic [15:0] i_write_data,
    input  wire logic        i_sda_in,
    output t_result          o_result
);

    logic [15:0] r_phase_ticks;
    t_step       r_step,     n_step;
    logic [15:0] r_pc,       n_pc;
    logic [2:0]  r_bit,      n_bit;
    logic [7:0]  r_shift,    n_shift;
    logic [15:0] r_received, n_received;
    logic        r_nack,     n_nack;
    logic [7:0]  r_addr,     n_addr;
    logic [7:0]  r_reg,      n_reg;
    logic [15:0] r_data,     n_data;
    logic        r_is_read,  n_is_read;
    logic [2:0]  r_stage,    n_stage;
    logic        r_half,     n_half;

    logic        start;
    t_step       step_e;
    logic [2:0]  stage_e;
    logic        done;

    assign start   = (r_step == ST_IDLE) && (i_opcode == OP_WRITE || i_opcode == OP_READ);
    assign step_e  = start ? ST_START_A : r_step;
    assign stage_e = start ? STAGE_ADDR : r_stage;

    // sequencer next state
    always_comb begin
        logic [15:0] p;
        logic [16:0] pc_inc;
        logic [2:0]  bit_inc;
        logic [2:0]  stage_inc;
        n_step     = step_e;
        n_addr     = start ? i_slave_addr : r_addr;
        n_reg      = start ? i_reg_ptr : r_reg;
        n_data     = start ? i_write_data : r_data;
        n_is_read  = start ? (i_opcode == OP_READ) : r_is_read;
        n_nack     = start ? 1'b0 : r_nack;
        n_stage    = stage_e;
        n_bit      = start ? 3'd0 : r_bit;
        n_pc       = start ? 16'd0 : r_pc;
        n_half     = start ? 1'b0 : r_half;
        n_shift    = r_shift;
        n_received = r_received;
        done       = 1'b0;
        p          = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;
        pc_inc     = {1'b0, n_pc} + 17'd1;
        bit_inc    = n_bit + 3'd1;
        stage_inc  = stage_e + 3'd1;
        if (step_e != ST_IDLE) begin
            if (pc_inc >= {1'b0, p}) begin
                n_pc = 16'd0;
                if (step_is_long(step_e) && !n_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    unique case (step_e)
                        ST_START_A:   n_step = ST_START_B;
                        ST_START_B:   n_step = ST_START_C;
                        ST_START_C: begin
                            n_shift = load_byte(stage_e, n_addr, n_reg, n_data);
                            n_bit   = 3'd0;
                            n_step  = ST_WBIT_LOW;
                        end
                        ST_WBIT_LOW:  n_step = ST_WBIT_HIGH;
                        ST_WBIT_HIGH: n_step = ST_WBIT_TAIL;
                        ST_WBIT_TAIL: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = bit_inc;
                            n_step  = (bit_inc == 3'd0) ? ST_SACK_HIGH : ST_WBIT_LOW;
                        end
                        ST_SACK_HIGH: begin
                            if (i_sda_in) begin
                                n_nack = 1'b1;
                            end
                            n_step = ST_SACK_LOW;
                        end
                        ST_SACK_LOW: begin
                            n_stage = stage_inc;
                            if (!n_is_read) begin
                                if (stage_inc < STAGE_ADDR_RD) begin
                                    n_shift = load_byte(stage_inc, n_addr, n_reg, n_data);
                                    n_bit   = 3'd0;
                                    n_step  = ST_WBIT_LOW;
                                end else begin
                                    n_step = ST_STOP_A;
                                end
                            end else if (stage_inc == STAGE_REG) begin
                                n_shift = load_byte(stage_inc, n_addr, n_reg, n_data);
                                n_bit   = 3'd0;
                                n_step  = ST_WBIT_LOW;
                            end else if (stage_inc == STAGE_DATA_HI) begin
                                n_step = ST_STOP_A;
                            end else begin
                                n_stage = STAGE_RD_HI;
                                n_shift = 8'd0;
                                n_bit   = 3'd0;
                                n_step  = ST_RBIT_LOW;
                            end
                        end
                        ST_RBIT_LOW:  n_step = ST_RBIT_HIGH;
                        ST_RBIT_HIGH: begin
                            n_shift = {r_shift[6:0], i_sda_in};
                            n_bit   = bit_inc;
                            n_step  = (bit_inc == 3'd0) ? ST_MACK_LOW : ST_RBIT_LOW;
                        end
                        ST_MACK_LOW:  n_step = ST_MACK_HIGH;
                        ST_MACK_HIGH: begin
                            if (stage_e == STAGE_RD_HI) begin
                                n_data  = {r_shift, 8'd0};
                                n_stage = STAGE_RD_LO;
                                n_shift = 8'd0;
                                n_bit   = 3'd0;
                                n_step  = ST_RBIT_LOW;
                            end else begin
                                n_received = n_data | {8'd0, r_shift};
                                n_stage    = STAGE_END;
                                n_step     = ST_STOP_A;
                            end
                        end
                        ST_STOP_A:    n_step = ST_STOP_B;
                        ST_STOP_B: begin
                            if (n_is_read && stage_e == STAGE_DATA_HI) begin
                                n_stage = STAGE_ADDR_RD;
                                n_step  = ST_START_A;
                            end else begin
                                n_step = ST_IDLE;
                                done   = 1'b1;
                            end
                        end
                        default:      n_step = ST_IDLE;
                    endcase
                end
            end else begin
                n_pc = pc_inc[15:0];
            end
        end
    end

    // pin levels, busy, done, read word and nack flag
    always_comb begin
        o_result           = '0;
        o_result.scl_level = 1'b1;
        o_result.sda_level = 1'b1;
        o_result.sda_drive = 1'b1;
        if (step_e != ST_IDLE) begin
            o_result.busy_res  = 1'b1;
            o_result.scl_level = step_scl(step_e);
            unique case (step_e)
                ST_START_B, ST_START_C, ST_STOP_A:
                    o_result.sda_level = 1'b0;
                ST_WBIT_LOW, ST_WBIT_HIGH, ST_WBIT_TAIL:
                    o_result.sda_level = r_shift[7];
                ST_SACK_HIGH, ST_SACK_LOW, ST_RBIT_LOW, ST_RBIT_HIGH:
                    o_result.sda_drive = 1'b0;
                ST_MACK_LOW, ST_MACK_HIGH:
                    o_result.sda_level = (stage_e == STAGE_RD_LO);
                default:
                    o_result.sda_level = 1'b1;
            endcase
        end
        o_result.done_res  = done;
        o_result.read_word = n_received;
        o_result.nack_seen = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_IDLE;
            r_pc       <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_received <= '0;
            r_nack     <= 1'b0;
            r_addr     <= '0;
            r_reg      <= '0;
            r_data     <= '0;
            r_is_read  <= 1'b0;
            r_stage    <= STAGE_ADDR;
            r_half     <= 1'b0;
        end else if (i_accept) begin
            r_step     <= n_step;
            r_pc       <= n_pc;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_received <= n_received;
            r_nack     <= n_nack;
            r_addr     <= n_addr;
            r_reg      <= n_reg;
            r_data     <= n_data;
            r_is_read  <= n_is_read;
            r_stage    <= n_stage;
            r_half     <= n_half;
        end
    end

endmodule

`default_nettype wire

[src/i2cwrm_out_reg.sv]
`default_nettype none

module i2cwrm_out_reg
    import i2cwrm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_accept,
    input  wire t_result i_result,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_in_stall  = r_valid && i_out_stall;
    assign o_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_accept) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[src/i2c_word_register_master.sv]
// I2C master for 16-bit register writes and reads, driving SCL and SDA.
// Input channel: i_in_valid / o_in_stall with i_opcode, i_slave_addr,
// i_reg_ptr, i_write_data and i_sda_in. Every transfer is one timing tick;
// opcode write or read starts a transaction when idle and is ignored when
// busy. Output channel: o_out_valid / i_out_stall, one result per tick with
// the pin levels, busy, done, the last read word and the nack flag.
// i_cfg_we / i_cfg_wdata load the ticks per short bit phase (zero acts as
// one); write it only while idle.
// A tick's result is registered and shows from the cycle after the tick
// is accepted. Throughput is one tick per clock while the output is not
// stalled, set by the single registered pass through the step sequencer;
// a new tick is taken while the previous result is being taken.
// When the receiver stalls with a result held, o_in_stall rises and the
// sequencer holds its state until the result is taken.
// Reset (synchronous, active low) returns the sequencer to idle, clears all
// held bytes and flags, sets the phase length to 100 and empties the output.
`default_nettype none

module i2c_word_register_master
    import i2cwrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_slave_addr,
    input  wire logic [7:0]  i_reg_ptr,
    input  wire logic [15:0] i_write_data,
    input  wire logic        i_sda_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_scl_level,
    output logic             o_sda_level,
    output logic             o_sda_drive,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [15:0]      o_read_word,
    output logic             o_nack_seen
);

    logic    accept;
    t_result seq_result;
    t_result out_result;

    i2cwrm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_slave_addr (i_slave_addr),
        .i_reg_ptr    (i_reg_ptr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_result     (seq_result)
    );

    i2cwrm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_result    (seq_result),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_scl_level = out_result.scl_level;
    assign o_sda_level = out_result.sda_level;
    assign o_sda_drive = out_result.sda_drive;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_word = out_result.read_word;
    assign o_nack_seen = out_result.nack_seen;

endmodule

`default_nettype wire

[src/i2cwrm_checker.sv]
`default_nettype none

module i2cwrm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_scl_level,
    input wire logic        o_sda_level,
    input wire logic        o_sda_drive,
    input wire logic        o_busy_res,
    input wire logic        o_done_res,
    input wire logic [15:0] o_read_word,
    input wire logic        o_nack_seen
);

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> o_busy_res)
        else $error("done outside a transaction");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (o_scl_level && o_sda_level && o_sda_drive))
        else $error("bus not released while idle");

    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sda_drive) |-> (o_sda_level && o_busy_res))
        else $error("released data line reported low");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_read_word) && $stable(o_scl_level)
             && $stable(o_nack_seen)))
        else $error("stalled result changed");

endmodule

bind i2c_word_register_master i2cwrm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_scl_level (o_scl_level),
    .o_sda_level (o_sda_level),
    .o_sda_drive (o_sda_drive),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_read_word (o_read_word),
    .o_nack_seen (o_nack_seen)
);

`default_nettype wire

[tb/i2c_word_register_master_checker.sv]
`timescale 1ns / 1ps

module i2c_word_register_master_checker
    import i2cwrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_slave_addr,
    input  logic [7:0]  i_reg_ptr,
    input  logic [15:0] i_write_data,
    input  logic        i_sda_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    input  logic        i_sda_drive,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [15:0] i_read_word,
    input  logic        i_nack_seen,
    output int          o_fail_count,
    output int          o_pending
);

    logic [15:0] phase_len;
    t_step       step_q;
    int unsigned phase_cnt;
    logic [2:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [15:0] word_rx;
    logic        nack_q;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_ptr;
    logic [15:0] data_q;
    logic        read_q;
    logic [2:0]  stage_q;
    logic        half_q;

    t_result     pin_levels_q[$];
    t_result     due;
    int          fail_total = 0;
    int          bad;

    function automatic void fetch_byte();
        case (stage_q)
            STAGE_ADDR:    shifter = dev_addr;
            STAGE_REG:     shifter = reg_ptr;
            STAGE_DATA_HI: shifter = data_q[15:8];
            STAGE_DATA_LO: shifter = data_q[7:0];
            default:       shifter = dev_addr + 8'd1;
        endcase
        bit_cnt = 3'd0;
    endfunction

    // advances the sequencer at the end of a segment; 1 when the final stop ends
    function automatic logic close_segment(input logic sda);
        logic fin;
        fin = 1'b0;
        case (step_q)
            ST_START_A: step_q = ST_START_B;
            ST_START_B: step_q = ST_START_C;
            ST_START_C: begin
                fetch_byte();
                step_q = ST_WBIT_LOW;
            end
            ST_WBIT_LOW:  step_q = ST_WBIT_HIGH;
            ST_WBIT_HIGH: step_q = ST_WBIT_TAIL;
            ST_WBIT_TAIL: begin
                shifter = {shifter[6:0], 1'b0};
                bit_cnt = bit_cnt + 3'd1;
                step_q = (bit_cnt == 3'd0) ? ST_SACK_HIGH : ST_WBIT_LOW;
            end
            ST_SACK_HIGH: begin
                if (sda) nack_q = 1'b1;
                step_q = ST_SACK_LOW;
            end
            ST_SACK_LOW: begin
                stage_q = stage_q + 3'd1;
                if (!read_q) begin
                    if (stage_q < STAGE_ADDR_RD) begin
                        fetch_byte();
                        step_q = ST_WBIT_LOW;
                    end else begin
                        step_q = ST_STOP_A;
                    end
                end else if (stage_q == STAGE_REG) begin
                    fetch_byte();
                    step_q = ST_WBIT_LOW;
                end else if (stage_q == STAGE_DATA_HI) begin
                    step_q = ST_STOP_A;
                end else begin
                    stage_q = STAGE_RD_HI;
                    shifter = 8'h00;
                    bit_cnt = 3'd0;
                    step_q = ST_RBIT_LOW;
                end
            end
            ST_RBIT_LOW:  step_q = ST_RBIT_HIGH;
            ST_RBIT_HIGH: begin
                shifter = {shifter[6:0], sda};
                bit_cnt = bit_cnt + 3'd1;
                step_q = (bit_cnt == 3'd0) ? ST_MACK_LOW : ST_RBIT_LOW;
            end
            ST_MACK_LOW:  step_q = ST_MACK_HIGH;
            ST_MACK_HIGH: begin
                if (stage_q == STAGE_RD_HI) begin
                    data_q = {shifter, 8'h00};
                    stage_q = STAGE_RD_LO;
                    shifter = 8'h00;
                    bit_cnt = 3'd0;
                    step_q = ST_RBIT_LOW;
                end else begin
                    word_rx = data_q | {8'h00, shifter};
                    stage_q = STAGE_END;
                    step_q = ST_STOP_A;
                end
            end
            ST_STOP_A: step_q = ST_STOP_B;
            ST_STOP_B: begin
                // pointer set done: stop, then a new start for the data read
                if (read_q && stage_q == STAGE_DATA_HI) begin
                    stage_q = STAGE_ADDR_RD;
                    step_q = ST_START_A;
                end else begin
                    step_q = ST_IDLE;
                    fin = 1'b1;
                end
            end
            default: step_q = ST_IDLE;
        endcase
        return fin;
    endfunction

    function automatic t_result pin_tick(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [7:0] regb, input logic [15:0] data,
                                         input logic sda);
        t_result     r;
        int unsigned span;
        logic        is_long;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res  = 1'b0;
        r.done_res  = 1'b0;
        if (step_q == ST_IDLE && (op == OP_WRITE || op == OP_READ)) begin
            dev_addr  = addr;
            reg_ptr   = regb;
            data_q    = data;
            read_q    = (op == OP_READ);
            nack_q    = 1'b0;
            stage_q   = STAGE_ADDR;
            bit_cnt   = 3'd0;
            phase_cnt = 0;
            half_q    = 1'b0;
            step_q    = ST_START_A;
        end
        if (step_q != ST_IDLE) begin
            span = (phase_len == 16'd0) ? 1 : phase_len;
            r.busy_res = 1'b1;
            is_long = 1'b0;
            case (step_q)
                ST_START_A: is_long = 1'b1;
                ST_START_B: begin
                    is_long = 1'b1;
                    r.sda_level = 1'b0;
                end
                ST_START_C: begin
                    is_long = 1'b1;
                    r.scl_level = 1'b0;
                    r.sda_level = 1'b0;
                end
                ST_WBIT_LOW, ST_WBIT_TAIL: begin
                    r.scl_level = 1'b0;
                    r.sda_level = shifter[7];
                end
                ST_WBIT_HIGH: r.sda_level = shifter[7];
                ST_SACK_HIGH: begin
                    is_long = 1'b1;
                    r.sda_drive = 1'b0;
                end
                ST_SACK_LOW: begin
                    is_long = 1'b1;
                    r.scl_level = 1'b0;
                    r.sda_drive = 1'b0;
                end
                ST_RBIT_LOW: begin
                    r.scl_level = 1'b0;
                    r.sda_drive = 1'b0;
                end
                ST_RBIT_HIGH: r.sda_drive = 1'b0;
                ST_MACK_LOW: begin
                    r.scl_level = 1'b0;
                    r.sda_level = (stage_q == STAGE_RD_LO);
                end
                ST_MACK_HIGH: r.sda_level = (stage_q == STAGE_RD_LO);
                ST_STOP_A: begin
                    is_long = 1'b1;
                    r.sda_level = 1'b0;
                end
                ST_STOP_B: is_long = 1'b1;
                default: ;
            endcase
            phase_cnt++;
            if (phase_cnt >= span) begin
                phase_cnt = 0;
                if (is_long && !half_q) begin
                    half_q = 1'b1;
                end else begin
                    half_q = 1'b0;
                    r.done_res = close_segment(sda);
                end
            end
        end
        r.read_word = word_rx;
        r.nack_seen = nack_q;
        return r;
    endfunction

    function automatic int field_check(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_len = PHASE_TICKS_RESET;
            step_q    = ST_IDLE;
            phase_cnt = 0;
            bit_cnt   = 3'd0;
            shifter   = 8'h00;
            word_rx   = 16'h0000;
            nack_q    = 1'b0;
            dev_addr  = 8'h00;
            reg_ptr   = 8'h00;
            data_q    = 16'h0000;
            read_q    = 1'b0;
            stage_q   = STAGE_ADDR;
            half_q    = 1'b0;
            pin_levels_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pin_levels_q.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fail_total++;
                end else begin
                    due = pin_levels_q.pop_front();
                    bad = field_check("scl_level", due.scl_level, i_scl_level)
                        + field_check("sda_level", due.sda_level, i_sda_level)
                        + field_check("sda_drive", due.sda_drive, i_sda_drive)
                        + field_check("busy_res", due.busy_res, i_busy_res)
                        + field_check("done_res", due.done_res, i_done_res)
                        + field_check("read_word", due.read_word, i_read_word)
                        + field_check("nack_seen", due.nack_seen, i_nack_seen);
                    if (bad != 0) fail_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pin_levels_q.push_back(pin_tick(i_opcode, i_slave_addr, i_reg_ptr,
                                                i_write_data, i_sda_in));
            end
            if (i_cfg_we) phase_len = i_cfg_wdata;
        end
        o_pending    <= pin_levels_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/i2c_word_register_master_tb.sv]
`timescale 1ns / 1ps

module i2c_word_register_master_tb;
    import i2cwrm_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int IDLE_LIMIT = 1000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_TICK;
    logic [7:0]  slave_addr = 8'h00;
    logic [7:0]  reg_ptr = 8'h00;
    logic [15:0] write_data = 16'h0000;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic        nack_seen;

    int          fail_count;
    int          pending;
    int          tx_sent = 0;
    int          rx_taken = 0;
    int          quiet_cycles = 0;
    logic        last_busy = 1'b0;
    bit          hold_off_req = 1'b0;

    i2c_word_register_master uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_slave_addr (slave_addr),
        .i_reg_ptr    (reg_ptr),
        .i_write_data (write_data),
        .i_sda_in     (sda_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_scl_level  (scl_level),
        .o_sda_level  (sda_level),
        .o_sda_drive  (sda_drive),
        .o_busy_res   (busy_res),
        .o_done_res   (done_res),
        .o_read_word  (read_word),
        .o_nack_seen  (nack_seen)
    );

    i2c_word_register_master_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_slave_addr (slave_addr),
        .i_reg_ptr    (reg_ptr),
        .i_write_data (write_data),
        .i_sda_in     (sda_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_scl_level  (scl_level),
        .i_sda_level  (sda_level),
        .i_sda_drive  (sda_drive),
        .i_busy_res   (busy_res),
        .i_done_res   (done_res),
        .i_read_word  (read_word),
        .i_nack_seen  (nack_seen),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) last_busy <= busy_res;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                rx_taken++;
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    gap = HOLD_OFF_CYCLES;
                end else if ((rx_taken / 80) % 3 == 1) begin
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 5);
                end
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic push_tick(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] regb, input logic [15:0] data,
                             input logic sda);
        int gap;
        gap = ((tx_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode     <= op;
        slave_addr <= addr;
        reg_ptr    <= regb;
        write_data <= data;
        sda_in     <= sda;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        tx_sent++;
    endtask

    // sda_mode: 0 or 1 holds the line, 2 random
    task automatic settle_idle(input int sda_mode);
        bit idle;
        idle = 1'b0;
        while (!idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
            if (!last_busy) begin
                idle = 1'b1;
            end else begin
                repeat (8) begin
                    push_tick(OP_TICK, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)),
                              (sda_mode > 1) ? 1'($urandom_range(0, 1)) : sda_mode[0]);
                end
            end
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic set_phase(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic bus_traffic(input int count);
        int pick;
        logic [1:0] op;
        repeat (count) begin
            pick = $urandom_range(0, 31);
            if (pick == 0) op = OP_SPARE;
            else if (pick < 3) op = OP_WRITE;
            else if (pick < 5) op = OP_READ;
            else op = OP_TICK;
            push_tick(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        push_tick(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0);
        push_tick(OP_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        push_tick(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        push_tick(OP_SPARE, 8'h00, 8'h00, 16'h0000, 1'b0);
        settle_idle(0);

        // zero length acts as one tick
        set_phase(16'h0000);
        push_tick(OP_WRITE, 8'hFF, 8'h00, 16'hFFFF, 1'b0);
        push_tick(OP_READ, 8'h12, 8'h34, 16'h5678, 1'b0);
        settle_idle(0);
        push_tick(OP_READ, 8'hFF, 8'hFF, 16'h0000, 1'b1);
        push_tick(OP_WRITE, 8'h00, 8'h00, 16'h0000, 1'b1);
        settle_idle(1);
        push_tick(OP_WRITE, 8'h00, 8'hFF, 16'h0000, 1'b1);
        push_tick(OP_SPARE, 8'hA5, 8'h5A, 16'hA5A5, 1'b0);
        settle_idle(2);
        push_tick(OP_READ, 8'h00, 8'h00, 16'hFFFF, 1'b0);
        settle_idle(0);

        set_phase(16'd1);
        bus_traffic(300);
        settle_idle(2);

        set_phase(16'd2);
        bus_traffic(200);
        settle_idle(2);

        set_phase(16'd1);
        hold_off_req = 1'b1;
        bus_traffic(250);
        settle_idle(2);

        set_phase(16'hFFFF);
        push_tick(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        bus_traffic(40);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
